// ----- sv/mrm_pkg.sv -----
// Shared types and constants for the 4x4 row multiply block.
`timescale 1ns / 1ps

package mrm_pkg;

    localparam int DIM       = 4;
    localparam int ROW_W     = 2;
    localparam int VAL_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int TDATA_W   = 136;
    localparam int PAD_W     = TDATA_W - ROW_W - DIM * VAL_W;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic [ROW_W-1:0]         t_row;

    // Item kind carried on the input tuser.
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_MUL  = 1'b1
    } t_mode;

    // Load enables for the two lane stages.
    typedef struct packed {
        logic s1;
        logic s2;
    } t_lane_en;

endpackage

// ----- sv/mrm_lane.sv -----
// One column lane: four products against a stored column, then pairwise sums.
`timescale 1ns / 1ps

module mrm_lane (
    input  logic              i_clk,
    input  mrm_pkg::t_lane_en i_en,
    input  mrm_pkg::t_val     i_a [mrm_pkg::DIM],
    input  mrm_pkg::t_val     i_b [mrm_pkg::DIM],
    output mrm_pkg::t_pair    o_pair [2]
);

    mrm_pkg::t_prod r_prod [mrm_pkg::DIM];
    mrm_pkg::t_pair r_pair [2];

    // Stage 1: one full-width signed product per row of the right matrix.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int k = 0; k < mrm_pkg::DIM; k++) begin
                r_prod[k] <= mrm_pkg::PROD_W'(i_a[k]) * mrm_pkg::PROD_W'(i_b[k]);
            end
        end
    end

    // Stage 2: exact pairwise sums.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_pair[0] <= mrm_pkg::PAIR_W'(r_prod[0]) + mrm_pkg::PAIR_W'(r_prod[1]);
            r_pair[1] <= mrm_pkg::PAIR_W'(r_prod[2]) + mrm_pkg::PAIR_W'(r_prod[3]);
        end
    end

    assign o_pair = r_pair;

endmodule

// ----- sv/mrm_merge.sv -----
// Final sum, floor shift and saturation of all lanes into the output register.
`timescale 1ns / 1ps

module mrm_merge (
    input  logic           i_clk,
    input  logic           i_en,
    input  mrm_pkg::t_row  i_row,
    input  mrm_pkg::t_pair i_pair [mrm_pkg::DIM][2],
    output mrm_pkg::t_row  o_row,
    output mrm_pkg::t_val  o_prod [mrm_pkg::DIM]
);

    logic signed [mrm_pkg::SUM_W-1:0] w_sum   [mrm_pkg::DIM];
    logic signed [mrm_pkg::SUM_W-1:0] w_shift [mrm_pkg::DIM];
    mrm_pkg::t_val                    w_sat   [mrm_pkg::DIM];
    logic [mrm_pkg::SUM_W-mrm_pkg::VAL_W:0] w_top [mrm_pkg::DIM];
    mrm_pkg::t_row                    r_row;
    mrm_pkg::t_val                    r_prod  [mrm_pkg::DIM];

    // The arithmetic shift of the exact sum is the floor of sum / 2^16.
    always_comb begin
        for (int c = 0; c < mrm_pkg::DIM; c++) begin
            w_sum[c]   = mrm_pkg::SUM_W'(i_pair[c][0]) + mrm_pkg::SUM_W'(i_pair[c][1]);
            w_shift[c] = w_sum[c] >>> mrm_pkg::FRAC_BITS;
            w_top[c]   = w_shift[c][mrm_pkg::SUM_W-1:mrm_pkg::VAL_W-1];
            if ((&w_top[c]) || !(|w_top[c])) begin
                w_sat[c] = w_shift[c][mrm_pkg::VAL_W-1:0];
            end else if (w_shift[c][mrm_pkg::SUM_W-1]) begin
                w_sat[c] = {1'b1, {(mrm_pkg::VAL_W-1){1'b0}}};
            end else begin
                w_sat[c] = {1'b0, {(mrm_pkg::VAL_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row  <= i_row;
            r_prod <= w_sat;
        end
    end

    assign o_row  = r_row;
    assign o_prod = r_prod;

endmodule

// ----- sv/matrix4x4_row_multiply.sv -----
// Top level of the 4x4 row-streamed matrix multiply, signed Q16.16.
//
// Usage: items arrive on the s_axis channel. s_axis_tuser selects the kind:
// a load item (tuser low) writes its four values as one row of the right
// matrix B, selected by the row field, and produces no result. A multiply
// item (tuser high) carries one row of the left matrix A and produces one
// result row on m_axis, the row index copied through.
// Each result element is the exact sum of four 32x32 products, shifted right
// by 16 with floor rounding and saturated to the 32-bit signed range.
// Throughput: one item per cycle unless the full pipeline is stalled at the
// output. Four column lanes each hold four multipliers, so a whole row is
// multiplied in the cycle it is accepted. The accepting edge loads the products;
// the result then passes the pair sum register and the output register to m_axis.
// A load takes effect at its own edge; a multiply accepted in the next
// cycle already sees the new row.
// Stalls: each stage moves forward when the stage after it is empty or
// moving, so bubbles are squeezed out and input transfers continue until
// all three stages hold results that the receiver has not taken.
// Reset clears the stage valid flags only; B is undefined until each row is
// loaded, and no multiply may read a row before it has been loaded.
`timescale 1ns / 1ps

module matrix4x4_row_multiply (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // row [1:0], value_0 [33:2], value_1 [65:34], value_2 [97:66],
    // value_3 [129:98], zero fill [135:130]
    input  logic [mrm_pkg::TDATA_W-1:0] s_axis_tdata,
    // mode [0]
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_row [1:0], product_0 [33:2], product_1 [65:34], product_2 [97:66],
    // product_3 [129:98], zero fill [135:130]
    output logic [mrm_pkg::TDATA_W-1:0] m_axis_tdata
);

    localparam int DIM = mrm_pkg::DIM;

    // Right matrix store, indexed [row][column]. Each lane reads a fixed column.
    mrm_pkg::t_val  r_b [DIM][DIM];

    mrm_pkg::t_val  w_a    [DIM];
    mrm_pkg::t_val  w_bcol [DIM][DIM];
    mrm_pkg::t_pair w_pair [DIM][2];
    mrm_pkg::t_val  w_prod [DIM];
    mrm_pkg::t_row  w_in_row;
    mrm_pkg::t_row  w_out_row;
    mrm_pkg::t_lane_en w_lane_en;

    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    mrm_pkg::t_row r_row1, r_row2;

    logic w_take1, w_take2, w_take3;
    logic w_accept, w_load, w_mul;

    assign w_in_row = s_axis_tdata[mrm_pkg::ROW_W-1:0];

    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            w_a[k] = s_axis_tdata[mrm_pkg::ROW_W + k*mrm_pkg::VAL_W +: mrm_pkg::VAL_W];
            for (int c = 0; c < DIM; c++) begin
                w_bcol[c][k] = r_b[k][c];
            end
        end
    end

    // Stage flow control: a stage may load when it is empty or draining.
    assign w_take3 = !r_v3 || m_axis_tready;
    assign w_take2 = !r_v2 || w_take3;
    assign w_take1 = !r_v1 || w_take2;

    assign s_axis_tready = w_take1;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_load   = w_accept && (s_axis_tuser == mrm_pkg::MODE_LOAD);
    assign w_mul    = w_accept && (s_axis_tuser == mrm_pkg::MODE_MUL);

    assign w_lane_en.s1 = w_take1 && w_mul;
    assign w_lane_en.s2 = w_take2 && r_v1;

    always_comb begin
        n_v1 = r_v1;
        n_v2 = r_v2;
        n_v3 = r_v3;
        if (w_take1) begin
            n_v1 = w_mul;
        end
        if (w_take2) begin
            n_v2 = r_v1;
        end
        if (w_take3) begin
            n_v3 = r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lane_en.s1) begin
            r_row1 <= w_in_row;
        end
        if (w_lane_en.s2) begin
            r_row2 <= r_row1;
        end
    end

    // A load replaces a whole row of B in one transfer.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int c = 0; c < DIM; c++) begin
                r_b[w_in_row][c] <= w_a[c];
            end
        end
    end

    for (genvar g = 0; g < DIM; g++) begin : g_lane
        mrm_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_lane_en),
            .i_a    (w_a),
            .i_b    (w_bcol[g]),
            .o_pair (w_pair[g])
        );
    end

    mrm_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_take3 && r_v2),
        .i_row  (r_row2),
        .i_pair (w_pair),
        .o_row  (w_out_row),
        .o_prod (w_prod)
    );

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{mrm_pkg::PAD_W{1'b0}},
                            w_prod[3], w_prod[2], w_prod[1], w_prod[0], w_out_row};

    // Input is refused whenever every stage holds a result and the output stalls.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !m_axis_tready) |-> !s_axis_tready)
        else $error("input ready while the whole pipeline is stalled");

    // A multiply transfer always occupies the first stage.
    a_mul_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul |=> r_v1)
        else $error("multiply item lost at the first stage");

    // An advancing first stage hands its item to the second stage.
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_take2) |=> r_v2)
        else $error("item lost between product and sum stages");

    // With nothing in the sum stage, a taken result leaves the output empty.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v2 && m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result appeared without an item in flight");

endmodule
